// ----- sv/mmh_pkg.sv -----
package mmh_pkg;

	localparam int LENGTH_BITS = 32;

	localparam logic [63:0] PAIRS10 = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] PAIRS01 = 64'h5555_5555_5555_5555;
	localparam logic [63:0] PI_LO   = 64'h243F_6A88_85A3_08D3;
	localparam logic [63:0] PI_HI   = 64'h4528_21E6_38D0_1377;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT_GO,
		S_INIT_WAIT,
		S_ROUND_GO,
		S_ROUND_WAIT,
		S_TAIL,
		S_FIN1_GO,
		S_FIN1_WAIT,
		S_FIN2_GO,
		S_FIN2_WAIT,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MUL_INIT,
		MUL_ROUND,
		MUL_FIN1,
		MUL_FIN2
	} mul_op_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_INIT,
		WB_ROUND,
		WB_FIN1,
		WB_EMIT
	} wb_t;

	typedef struct packed {
		logic    load;
		logic    mul_start;
		mul_op_t mul_op;
		wb_t     wb;
		logic    tail;
	} cmd_t;

	typedef struct packed {
		logic in_msg;
		logic more;
		logic mul_done;
		logic out_free;
	} status_t;

endpackage

// ----- sv/mmh_mul.sv -----
module mmh_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic         busy_q;
	logic [2:0]   step_q;
	logic         done_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_s1;
	logic [1:0]   pidx_s1;
	logic [31:0]  op_x;
	logic [31:0]  op_y;
	logic [127:0] pp_shifted;

	// partial products: ll, lh, hl, hh
	always_comb begin
		case (step_q[1:0])
			2'd0: begin
				op_x = a_q[31:0];
				op_y = b_q[31:0];
			end
			2'd1: begin
				op_x = a_q[31:0];
				op_y = b_q[63:32];
			end
			2'd2: begin
				op_x = a_q[63:32];
				op_y = b_q[31:0];
			end
			default: begin
				op_x = a_q[63:32];
				op_y = b_q[63:32];
			end
		endcase
	end

	always_comb begin
		case (pidx_s1)
			2'd0:    pp_shifted = 128'(pp_s1);
			2'd3:    pp_shifted = {pp_s1, 64'd0};
			default: pp_shifted = {32'd0, pp_s1, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q != 3'd4) begin
				pp_s1   <= op_x * op_y;
				pidx_s1 <= step_q[1:0];
			end
			if (step_q != 3'd0) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- sv/mmh_dp.sv -----
module mmh_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mmh_pkg::cmd_t               cmd,
	output mmh_pkg::status_t            status,
	input  logic                        seed_we,
	input  logic [63:0]                 seed_data,
	input  logic [31:0]                 msg_length,
	input  logic [63:0]                 word_low,
	input  logic [63:0]                 word_high,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [63:0]                 hash_value
);

	logic [63:0]                       seed_q;
	logic [63:0]                       lane_a_q;
	logic [63:0]                       lane_b_q;
	logic [63:0]                       mix_a_q;
	logic [63:0]                       mix_b_q;
	logic [mmh_pkg::LENGTH_BITS-1:0]   left_q;
	logic                              in_msg_q;
	logic [63:0]                       w0_q;
	logic [63:0]                       w1_q;
	logic [63:0]                       hash_q;
	logic                              out_valid_q;

	logic [63:0]  mul_a;
	logic [63:0]  mul_b;
	logic         mul_done;
	logic [127:0] prod;
	logic [63:0]  prod_lo;
	logic [63:0]  prod_hi;
	logic [63:0]  len64;
	logic         more;

	logic [127:0] blk;
	logic [4:0]   n;
	logic [1:0]   mo;
	logic [3:0]   off_a;
	logic [3:0]   off_bh;
	logic [3:0]   off_bl;
	logic [63:0]  tail_a;
	logic [63:0]  tail_b;
	logic [63:0]  byte_mask;

	function automatic logic [63:0] half_swap(input logic [63:0] w);
		return {w[31:0], w[63:32]};
	endfunction

	// 32-bit little-endian read at a byte offset, wrapping inside the block
	function automatic logic [31:0] blk_u32(input logic [127:0] bk, input logic [3:0] off);
		logic [255:0] dbl;
		dbl = {bk, bk} >> {off, 3'b000};
		return dbl[31:0];
	endfunction

	assign prod_lo = prod[63:0];
	assign prod_hi = prod[127:64];
	assign len64   = 64'(left_q);
	assign more    = left_q > mmh_pkg::LENGTH_BITS'(16);

	always_comb begin
		case (cmd.mul_op)
			mmh_pkg::MUL_INIT: begin
				mul_a = mmh_pkg::PI_HI ^ len64 ^ (seed_q & mmh_pkg::PAIRS10);
				mul_b = mmh_pkg::PI_LO ^ len64 ^ (seed_q & mmh_pkg::PAIRS01);
			end
			mmh_pkg::MUL_ROUND: begin
				mul_a = half_swap(w0_q) ^ lane_a_q;
				mul_b = half_swap(w1_q) ^ lane_b_q;
			end
			mmh_pkg::MUL_FIN1: begin
				mul_a = lane_a_q;
				mul_b = lane_b_q;
			end
			default: begin
				mul_a = lane_a_q ^ mix_a_q;
				mul_b = lane_b_q;
			end
		endcase
	end

	mmh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// tail fold of the last 0..16 bytes
	always_comb begin
		blk       = {w1_q, w0_q};
		n         = left_q[4:0];
		mo        = n[4:3];
		off_a     = 4'(n - 5'd4);
		off_bh    = {mo, 2'b00};
		off_bl    = 4'(n - 5'd4 - {1'b0, mo, 2'b00});
		byte_mask = (64'd1 << {n, 3'b000}) - 64'd1;
		if (n > 5'd3) begin
			tail_a = {blk_u32(blk, 4'd0), blk_u32(blk, off_a)};
			tail_b = {blk_u32(blk, off_bh), blk_u32(blk, off_bl)};
		end else begin
			tail_a = w0_q & byte_mask;
			tail_b = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			lane_a_q    <= '0;
			lane_b_q    <= '0;
			mix_a_q     <= mmh_pkg::PAIRS01;
			mix_b_q     <= mmh_pkg::PAIRS10;
			left_q      <= '0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_data;
			end
			if (cmd.load) begin
				if (!in_msg_q) begin
					left_q  <= mmh_pkg::LENGTH_BITS'(msg_length);
					mix_a_q <= mmh_pkg::PAIRS01;
					mix_b_q <= mmh_pkg::PAIRS10;
				end else if (more) begin
					left_q <= left_q - mmh_pkg::LENGTH_BITS'(16);
				end
			end
			if (cmd.tail) begin
				lane_a_q <= lane_a_q ^ tail_a;
				lane_b_q <= lane_b_q ^ tail_b;
				left_q   <= '0;
				in_msg_q <= 1'b0;
			end
			case (cmd.wb)
				mmh_pkg::WB_INIT: begin
					lane_a_q <= prod_lo;
					lane_b_q <= prod_hi;
					if (more) begin
						mix_a_q  <= mix_a_q ^ prod_lo;
						mix_b_q  <= mix_b_q ^ prod_hi;
						left_q   <= left_q - mmh_pkg::LENGTH_BITS'(16);
						in_msg_q <= 1'b1;
					end
				end
				mmh_pkg::WB_ROUND: begin
					lane_a_q <= prod_lo + mix_a_q;
					lane_b_q <= prod_hi + mix_b_q;
				end
				mmh_pkg::WB_FIN1: begin
					lane_a_q <= prod_lo;
					lane_b_q <= prod_hi;
				end
				default: begin
				end
			endcase
			if (cmd.wb == mmh_pkg::WB_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w0_q <= word_low;
			w1_q <= word_high;
		end
		if (cmd.wb == mmh_pkg::WB_EMIT) begin
			hash_q <= prod_lo ^ prod_hi;
		end
	end

	assign status.in_msg   = in_msg_q;
	assign status.more     = more;
	assign status.mul_done = mul_done;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

// ----- sv/mmh_ctrl.sv -----
module mmh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mmh_pkg::status_t status,
	output mmh_pkg::cmd_t    cmd
);

	mmh_pkg::state_t state_q;
	mmh_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.mul_op    = mmh_pkg::MUL_INIT;
		cmd.wb        = mmh_pkg::WB_NONE;
		cmd.tail      = 1'b0;
		case (state_q)
			mmh_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!status.in_msg) begin
						state_d = mmh_pkg::S_INIT_GO;
					end else if (status.more) begin
						state_d = mmh_pkg::S_ROUND_GO;
					end else begin
						state_d = mmh_pkg::S_TAIL;
					end
				end
			end
			mmh_pkg::S_INIT_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = mmh_pkg::MUL_INIT;
				state_d       = mmh_pkg::S_INIT_WAIT;
			end
			mmh_pkg::S_INIT_WAIT: begin
				if (status.mul_done) begin
					cmd.wb  = mmh_pkg::WB_INIT;
					state_d = status.more ? mmh_pkg::S_ROUND_GO : mmh_pkg::S_TAIL;
				end
			end
			mmh_pkg::S_ROUND_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = mmh_pkg::MUL_ROUND;
				state_d       = mmh_pkg::S_ROUND_WAIT;
			end
			mmh_pkg::S_ROUND_WAIT: begin
				if (status.mul_done) begin
					cmd.wb  = mmh_pkg::WB_ROUND;
					state_d = mmh_pkg::S_IDLE;
				end
			end
			mmh_pkg::S_TAIL: begin
				cmd.tail = 1'b1;
				state_d  = mmh_pkg::S_FIN1_GO;
			end
			mmh_pkg::S_FIN1_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = mmh_pkg::MUL_FIN1;
				state_d       = mmh_pkg::S_FIN1_WAIT;
			end
			mmh_pkg::S_FIN1_WAIT: begin
				if (status.mul_done) begin
					cmd.wb  = mmh_pkg::WB_FIN1;
					state_d = mmh_pkg::S_FIN2_GO;
				end
			end
			mmh_pkg::S_FIN2_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = mmh_pkg::MUL_FIN2;
				state_d       = mmh_pkg::S_FIN2_WAIT;
			end
			mmh_pkg::S_FIN2_WAIT: begin
				if (status.mul_done) begin
					state_d = mmh_pkg::S_EMIT;
				end
			end
			mmh_pkg::S_EMIT: begin
				cmd.mul_op = mmh_pkg::MUL_FIN2;
				if (status.out_free) begin
					cmd.wb  = mmh_pkg::WB_EMIT;
					state_d = mmh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mmh_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/multiply_mix_hash64.sv -----
// 64-bit multiply-mix hash over a stream of 16-byte blocks.
// Input channel (in_valid / in_stall): one beat per 16-byte block, little-endian
// in word_low / word_high. msg_length is taken from the first beat of a message
// only; a message of n bytes takes max(1, ceil(n/16)) beats.
// Output channel (out_valid / out_stall): one beat carrying hash_value per message.
// Config channel (cfg_valid / cfg_ready): writes hash_seed; cfg_ready is always
// high. Write it only between messages; it applies from the next message.
// Every 64x64 multiply runs on one shared 32x32 multiplier; the four partial
// products are formed in turn, registered and added into an accumulator.
// After a middle block the next beat is accepted once its round multiply is written
// back (for the first block of a long message, after its initial multiply too).
// The last block gives its hash after the tail fold and two finishing multiplies,
// plus an initial one for a one-beat message. One block is worked on at a time.
// The result sits in an output register: the next block is accepted while a
// hash still waits there. If a second hash is ready before the first is taken,
// in_stall stays high until out_stall releases.
// Reset (arst_n low) clears the seed to zero, drops any partial message and
// empties the output register.
module multiply_mix_hash64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] msg_length,
	input  logic [63:0] word_low,
	input  logic [63:0] word_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] hash_seed
);

	mmh_pkg::cmd_t    cmd;
	mmh_pkg::status_t status;

	assign cfg_ready = 1'b1;

	mmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mmh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.seed_we    (cfg_valid),
		.seed_data  (hash_seed),
		.msg_length (msg_length),
		.word_low   (word_low),
		.word_high  (word_high),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.hash_value (hash_value)
	);

endmodule
